@@ hw/rtl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, codes and helpers of the binned interval summary block.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  localparam int MaxSplitBins = 63;
  localparam int SplitW       = 7;
  localparam logic [31:0] M32 = 32'hFFFF_FFFF;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] M63 = 63'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] OP_ITEM = 2'd0;
  localparam logic [1:0] OP_EOC  = 2'd1;
  localparam logic [1:0] OP_EOA  = 2'd2;

  typedef enum logic [1:0] {CL_ITEM, CL_EOC, CL_EOA} item_cls_t;

  typedef struct packed {
    item_cls_t          cls;
    logic [15:0]        chrom;
    logic [31:0]        len;
    logic [31:0]        s;
    logic [31:0]        e;
    logic signed [31:0] v;
    logic [31:0]        size;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        chrom;
    logic [31:0]        first;
    logic [31:0]        last_b;
    logic [47:0]        count;
    logic signed [31:0] min;
    logic signed [31:0] max;
    logic signed [63:0] sum;
    logic [62:0]        sumsq;
    logic               err;
    logic               fin;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COUNT, ST_ERROR, ST_SQ, ST_F_VN, ST_F_LO, ST_F_HI, ST_F_APPLY,
    ST_CLOSE, ST_OPEN, ST_SPLIT, ST_EMIT, ST_FLUSH, ST_TOTAL
  } bis_state_t;

  typedef enum logic [1:0] {PH_TOTAL, PH_SPLIT, PH_FINAL} fold_phase_t;

  function automatic logic [31:0] clip_end(input logic [31:0] lo,
                                            input logic [31:0] len,
                                            input logic [31:0] bw);
    logic [32:0] w;
    logic [32:0] e;
    logic [31:0] r;
    w = (bw == 32'd0) ? 33'd1 : {1'b0, bw};
    e = {1'b0, lo} + w;
    r = e[32] ? M32 : e[31:0];
    if (len > lo && r > len) r = len;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bis_front.sv @@
// ----------------------------------------------------------------------------
// bis_front
// Accepts input beats, drops beats with an unknown op, clamps and sizes intervals, queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_front import bis_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         in_op,
  input  wire logic [15:0]        in_chrom_id,
  input  wire logic [31:0]        in_chrom_length,
  input  wire logic [31:0]        in_item_start,
  input  wire logic [31:0]        in_item_end,
  input  wire logic signed [31:0] in_item_value,
  output item_beat_t              iq_beat,
  input  wire logic               iq_pop
);

  item_t       q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  item_t       cls_item;
  logic        keep;
  logic        wr, rd;

  always_comb begin
    cls_item.chrom = in_chrom_id;
    cls_item.len   = in_chrom_length;
    cls_item.s     = in_item_start;
    cls_item.e     = (in_item_end < in_item_start) ? in_item_start : in_item_end;
    cls_item.v     = in_item_value;
    cls_item.size  = cls_item.e - in_item_start;
    keep           = 1'b1;
    case (in_op)
      OP_ITEM: cls_item.cls = CL_ITEM;
      OP_EOC:  cls_item.cls = CL_EOC;
      OP_EOA:  cls_item.cls = CL_EOA;
      default: begin
        cls_item.cls = CL_ITEM;
        keep         = 1'b0;
      end
    endcase
  end

  assign full          = (cnt_r == 2'd2);
  assign wr            = push && !full && keep;
  assign rd            = iq_pop && (cnt_r != 2'd0);
  assign iq_beat.valid = (cnt_r != 2'd0);
  assign iq_beat.item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr) wr_ptr_r <= !wr_ptr_r;
      if (rd) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wr_ptr_r] <= cls_item;
  end

endmodule

`default_nettype wire

@@ hw/rtl/bis_outq.sv @@
// ----------------------------------------------------------------------------
// bis_outq
// Two-entry result queue between the back sequencer and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_outq import bis_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_push,
  input  result_t      res_data,
  output logic         res_full,
  output logic         empty,
  input  wire logic    pop,
  output result_t      head
);

  result_t    q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;
  assign head     = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr) wr_ptr_r <= !wr_ptr_r;
      if (rd) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wr_ptr_r] <= res_data;
  end

endmodule

`default_nettype wire

@@ hw/rtl/bis_back.sv @@
// ----------------------------------------------------------------------------
// bis_back
// Sequencer that counts splits, folds values into bins and totals and emits
// results, sharing one 33x33 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_back import bis_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] bin_width,
  input  item_beat_t       iq_beat,
  output logic             iq_pop,
  output logic             res_push,
  output result_t          res_data,
  input  wire logic        res_full
);

  bis_state_t  state_r, state_nxt;
  item_t       item_r;
  logic        close_r;
  logic [SplitW-1:0] splits_r, left_r;
  logic [31:0] cnt_hi_r;
  fold_phase_t phase_r;
  logic [31:0] n_r, rem_r, cur_r;
  logic [46:0] sq_r;
  logic signed [63:0] vn_r;
  logic [55:0] plo_r;
  logic signed [65:0] prod_r;

  logic        bin_open_r;
  logic [15:0] bin_chrom_r;
  logic [31:0] bin_lo_r, bin_hi_r, bin_bases_r;
  logic signed [31:0] bin_min_r, bin_max_r;
  logic signed [63:0] bin_sum_r;
  logic [62:0] bin_sumsq_r;

  logic        tot_seen_r;
  logic [47:0] tot_bases_r;
  logic signed [31:0] tot_min_r, tot_max_r;
  logic signed [63:0] tot_sum_r;
  logic [62:0] tot_sumsq_r;

  logic signed [32:0] mul_a, mul_b, mag;
  logic        in_close;
  logic [31:0] in_hi;
  logic [7:0]  bins_needed;

  logic        is_tot;
  logic signed [63:0] f_sum_in;
  logic [62:0] f_sq_in;
  logic signed [64:0] f_sum_w;
  logic signed [63:0] f_sum;
  logic [79:0] q_full;
  logic [62:0] q;
  logic [63:0] f_sq_w;
  logic [62:0] f_sq;
  logic [32:0] b_bases_w;
  logic [48:0] t_bases_w;

  logic [31:0] sp_a, sp_b, sp_ov;
  logic [31:0] start_hi;

  result_t     bin_res;
  result_t     tot_res;
  result_t     err_res;

  // entry decode
  always_comb begin
    in_close = bin_open_r && (iq_beat.item.chrom != bin_chrom_r ||
                              iq_beat.item.s >= bin_hi_r);
    in_hi    = (in_close || !bin_open_r) ?
               clip_end(iq_beat.item.s, iq_beat.item.len, bin_width) : bin_hi_r;
    bins_needed = {7'd0, close_r} + {1'b0, splits_r};
  end

  // shared multiplier operands
  always_comb begin
    mag = item_r.v[31] ? -{item_r.v[31], item_r.v} : {item_r.v[31], item_r.v};
    case (state_r)
      ST_SQ: begin
        mul_a = mag;
        mul_b = mag;
      end
      ST_F_VN: begin
        mul_a = {item_r.v[31], item_r.v};
        mul_b = {1'b0, n_r};
      end
      ST_F_LO: begin
        mul_a = {9'd0, sq_r[23:0]};
        mul_b = {1'b0, n_r};
      end
      ST_F_HI: begin
        mul_a = {10'd0, sq_r[46:24]};
        mul_b = {1'b0, n_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // fold arithmetic
  always_comb begin
    is_tot   = (phase_r == PH_TOTAL);
    f_sum_in = is_tot ? tot_sum_r : bin_sum_r;
    f_sq_in  = is_tot ? tot_sumsq_r : bin_sumsq_r;
    f_sum_w  = {f_sum_in[63], f_sum_in} + {vn_r[63], vn_r};
    if (f_sum_w[64] != f_sum_w[63])
      f_sum = f_sum_w[64] ? {1'b1, 63'd0} : {1'b0, M63};
    else
      f_sum = f_sum_w[63:0];
    q_full = {1'b0, prod_r[54:0], 24'd0} + {24'd0, plo_r};
    q      = (q_full > {17'd0, M63}) ? M63 : q_full[62:0];
    f_sq_w = {1'b0, f_sq_in} + {1'b0, q};
    f_sq   = f_sq_w[63] ? M63 : f_sq_w[62:0];
    b_bases_w = {1'b0, bin_bases_r} + {1'b0, n_r};
    t_bases_w = {1'b0, tot_bases_r} + {17'd0, n_r};
  end

  // split overlap
  always_comb begin
    sp_a     = (cur_r > bin_lo_r) ? cur_r : bin_lo_r;
    sp_b     = (item_r.e < bin_hi_r) ? item_r.e : bin_hi_r;
    sp_ov    = (sp_b > sp_a) ? sp_b - sp_a : 32'd0;
    start_hi = clip_end((state_r == ST_EMIT) ? bin_hi_r : item_r.s, item_r.len,
                        bin_width);
  end

  always_comb begin
    bin_res.kind   = 1'b0;
    bin_res.chrom  = bin_chrom_r;
    bin_res.first  = bin_lo_r;
    bin_res.last_b = bin_hi_r;
    bin_res.count  = {16'd0, bin_bases_r};
    bin_res.min    = bin_min_r;
    bin_res.max    = bin_max_r;
    bin_res.sum    = bin_sum_r;
    bin_res.sumsq  = bin_sumsq_r;
    bin_res.err    = 1'b0;
    bin_res.fin    = 1'b0;
    tot_res        = bin_res;
    tot_res.kind   = 1'b1;
    tot_res.chrom  = '0;
    tot_res.first  = '0;
    tot_res.last_b = '0;
    tot_res.count  = tot_bases_r;
    tot_res.min    = tot_min_r;
    tot_res.max    = tot_max_r;
    tot_res.sum    = tot_sum_r;
    tot_res.sumsq  = tot_sumsq_r;
    tot_res.fin    = 1'b1;
    err_res        = '0;
    err_res.err    = 1'b1;
    err_res.fin    = 1'b1;
  end

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    iq_pop    = 1'b0;
    res_push  = 1'b0;
    res_data  = bin_res;
    case (state_r)
      ST_IDLE: begin
        if (iq_beat.valid) begin
          iq_pop    = 1'b1;
          state_nxt = (iq_beat.item.cls == CL_ITEM) ? ST_COUNT : ST_FLUSH;
        end
      end
      ST_COUNT: begin
        if (!(item_r.e > cnt_hi_r && splits_r <= SplitW'(MaxSplitBins))) begin
          state_nxt = (bins_needed > 8'(MaxSplitBins)) ? ST_ERROR : ST_SQ;
        end
      end
      ST_ERROR: begin
        res_data = err_res;
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SQ:   state_nxt = ST_F_VN;
      ST_F_VN: state_nxt = ST_F_LO;
      ST_F_LO: state_nxt = ST_F_HI;
      ST_F_HI: state_nxt = ST_F_APPLY;
      ST_F_APPLY: begin
        case (phase_r)
          PH_TOTAL: begin
            if (close_r) state_nxt = ST_CLOSE;
            else if (!bin_open_r) state_nxt = ST_OPEN;
            else state_nxt = ST_SPLIT;
          end
          PH_SPLIT: state_nxt = ST_EMIT;
          default:  state_nxt = ST_IDLE;
        endcase
      end
      ST_CLOSE: begin
        res_data.fin = (splits_r == '0);
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_OPEN;
        end
      end
      ST_OPEN:  state_nxt = ST_SPLIT;
      ST_SPLIT: state_nxt = ST_F_VN;
      ST_EMIT: begin
        res_data.fin = (left_r == SplitW'(1));
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_FLUSH: begin
        res_data.fin = (item_r.cls == CL_EOC);
        if (!bin_open_r || !res_full) begin
          res_push  = bin_open_r;
          state_nxt = (item_r.cls == CL_EOA) ? ST_TOTAL : ST_IDLE;
        end
      end
      ST_TOTAL: begin
        res_data = tot_res;
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        if (iq_beat.valid) begin
          item_r   <= iq_beat.item;
          close_r  <= in_close;
          cnt_hi_r <= in_hi;
          splits_r <= '0;
        end
      end
      ST_COUNT: begin
        if (item_r.e > cnt_hi_r && splits_r <= SplitW'(MaxSplitBins)) begin
          cnt_hi_r <= clip_end(cnt_hi_r, item_r.len, bin_width);
          splits_r <= splits_r + SplitW'(1);
        end else begin
          left_r  <= splits_r;
          n_r     <= item_r.size;
          phase_r <= PH_TOTAL;
        end
      end
      ST_F_VN: begin
        if (phase_r == PH_TOTAL) sq_r <= prod_r[62:16];
      end
      ST_F_LO: vn_r  <= prod_r[63:0];
      ST_F_HI: plo_r <= prod_r[55:0];
      ST_F_APPLY: begin
        if (phase_r == PH_TOTAL) begin
          rem_r <= item_r.size;
          cur_r <= item_r.s;
        end
      end
      ST_SPLIT: begin
        if (item_r.e > bin_hi_r) begin
          n_r     <= sp_ov;
          rem_r   <= (sp_ov <= rem_r) ? rem_r - sp_ov : 32'd0;
          phase_r <= PH_SPLIT;
        end else begin
          n_r     <= rem_r;
          phase_r <= PH_FINAL;
        end
      end
      ST_EMIT: begin
        if (!res_full) begin
          left_r <= left_r - SplitW'(1);
          cur_r  <= bin_hi_r;
        end
      end
      default: ;
    endcase
  end

  // bin and total state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_open_r  <= 1'b0;
      bin_chrom_r <= '0;
      bin_lo_r    <= '0;
      bin_hi_r    <= '0;
      bin_bases_r <= '0;
      bin_min_r   <= '0;
      bin_max_r   <= '0;
      bin_sum_r   <= '0;
      bin_sumsq_r <= '0;
      tot_seen_r  <= 1'b0;
      tot_bases_r <= '0;
      tot_min_r   <= '0;
      tot_max_r   <= '0;
      tot_sum_r   <= '0;
      tot_sumsq_r <= '0;
    end else begin
      case (state_r)
        ST_F_APPLY: begin
          if (is_tot) begin
            tot_seen_r  <= 1'b1;
            tot_bases_r <= t_bases_w[48] ? M48 : t_bases_w[47:0];
            if (!tot_seen_r || item_r.v < tot_min_r) tot_min_r <= item_r.v;
            if (!tot_seen_r || item_r.v > tot_max_r) tot_max_r <= item_r.v;
            tot_sum_r   <= f_sum;
            tot_sumsq_r <= f_sq;
          end else begin
            bin_bases_r <= b_bases_w[32] ? M32 : b_bases_w[31:0];
            if (item_r.v < bin_min_r) bin_min_r <= item_r.v;
            if (item_r.v > bin_max_r) bin_max_r <= item_r.v;
            bin_sum_r   <= f_sum;
            bin_sumsq_r <= f_sq;
          end
        end
        ST_CLOSE: begin
          if (!res_full) bin_open_r <= 1'b0;
        end
        ST_OPEN, ST_EMIT: begin
          if (state_r == ST_OPEN || !res_full) begin
            bin_open_r  <= 1'b1;
            if (state_r == ST_OPEN) bin_chrom_r <= item_r.chrom;
            bin_lo_r    <= (state_r == ST_EMIT) ? bin_hi_r : item_r.s;
            bin_hi_r    <= start_hi;
            bin_bases_r <= '0;
            bin_min_r   <= item_r.v;
            bin_max_r   <= item_r.v;
            bin_sum_r   <= '0;
            bin_sumsq_r <= '0;
          end
        end
        ST_FLUSH: begin
          if (!res_full) bin_open_r <= 1'b0;
        end
        ST_TOTAL: begin
          if (!res_full) begin
            tot_seen_r  <= 1'b0;
            tot_bases_r <= '0;
            tot_min_r   <= '0;
            tot_max_r   <= '0;
            tot_sum_r   <= '0;
            tot_sumsq_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    iq_pop |=> state_r != ST_IDLE)
    else $error("item taken but sequencer stayed idle");

  a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COUNT |-> splits_r <= SplitW'(MaxSplitBins + 1))
    else $error("split count ran past its bound");

  a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> left_r != '0)
    else $error("split bin emitted with none left");

endmodule

`default_nettype wire

@@ hw/rtl/binned_interval_summary.sv @@
// ----------------------------------------------------------------------------
// binned_interval_summary
// Folds sorted intervals into fixed-width summary bins with running totals.
//
//   channel  direction  handshake                  payload
//   input    in         push / full                in_op .. in_item_value
//   result   out        empty / pop                out_kind .. out_last
//   config   in         psel penable pwrite pready paddr pwdata prdata
//
// an interval item is handled in steps: splits are counted one bin at a time, the
// value is squared, then folded into the totals and into each bin it covers
// the pace is set by the shared 33x33 multiplier, used once for the square
// and three times per fold
// reset is synchronous and clears the queues and all bin and total state
// the front queue takes beats while the back is busy; a full result queue
// stalls only the back
// ----------------------------------------------------------------------------
`default_nettype none

module binned_interval_summary import bis_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         in_op,
  input  wire logic [15:0]        in_chrom_id,
  input  wire logic [31:0]        in_chrom_length,
  input  wire logic [31:0]        in_item_start,
  input  wire logic [31:0]        in_item_end,
  input  wire logic signed [31:0] in_item_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    out_kind,
  output logic [15:0]             out_out_chrom,
  output logic [31:0]             out_bin_first,
  output logic [31:0]             out_bin_last,
  output logic [47:0]             out_valid_count,
  output logic signed [31:0]      out_min_val,
  output logic signed [31:0]      out_max_val,
  output logic signed [63:0]      out_sum_data,
  output logic [62:0]             out_sum_squares,
  output logic                    out_error,
  output logic                    out_last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [31:0] bin_width_r;
  item_beat_t  iq_beat;
  logic        iq_pop;
  logic        res_push, res_full;
  result_t     res_data, head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? bin_width_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r <= 32'd256;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      bin_width_r <= pwdata;
    end
  end

  bis_front u_front (
    .clk, .rst_n, .push, .full,
    .in_op, .in_chrom_id, .in_chrom_length, .in_item_start, .in_item_end,
    .in_item_value,
    .iq_beat, .iq_pop
  );

  bis_back u_back (
    .clk, .rst_n,
    .bin_width (bin_width_r),
    .iq_beat, .iq_pop,
    .res_push, .res_data, .res_full
  );

  bis_outq u_outq (
    .clk, .rst_n, .res_push, .res_data, .res_full,
    .empty, .pop, .head
  );

  assign out_kind        = head.kind;
  assign out_out_chrom   = head.chrom;
  assign out_bin_first   = head.first;
  assign out_bin_last    = head.last_b;
  assign out_valid_count = head.count;
  assign out_min_val     = head.min;
  assign out_max_val     = head.max;
  assign out_sum_data    = head.sum;
  assign out_sum_squares = head.sumsq;
  assign out_error       = head.err;
  assign out_last        = head.fin;

endmodule

`default_nettype wire

@@ sim/binned_interval_summary_test.sv @@
// ----------------------------------------------------------------------------
// binned_interval_summary_test
// Drives interval items and end marks into the binned summary block under
// random gaps and stalls, predicts every bin, total and error beat, and compares
// them field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binned_interval_summary_test;
  import bis_pkg::*;

  localparam logic [2:0] ADDR_BIN_WIDTH = 3'd0;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic [15:0]        chrom;
    logic [31:0]        len;
    logic [31:0]        s;
    logic [31:0]        e;
    logic signed [31:0] v;
  } interval_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        chrom;
    logic [31:0]        first;
    logic [31:0]        last_b;
    logic [47:0]        count;
    logic signed [31:0] min;
    logic signed [31:0] max;
    logic signed [63:0] sum;
    logic [62:0]        sumsq;
    logic               err;
    logic               fin;
  } summary_t;

  class bin_summary_predictor;
    logic [31:0] width_q;
    bit open_q;
    logic [15:0] chrom_q;
    logic [31:0] lo_q, hi_q, bases_q;
    logic signed [63:0] bmin, bmax, bsum;
    logic [63:0] bsq;
    bit seen_q;
    logic [63:0] tbases;
    logic signed [63:0] tmin, tmax, tsum;
    logic [63:0] tsq;
    summary_t pending[$];
    int mismatches;

    function void clear();
      width_q = 32'd256; open_q = 0; chrom_q = 0; lo_q = 0; hi_q = 0; bases_q = 0;
      bmin = 0; bmax = 0; bsum = 0; bsq = 0;
      seen_q = 0; tbases = 0; tmin = 0; tmax = 0; tsum = 0; tsq = 0;
    endfunction

    function logic [31:0] bin_end(logic [31:0] lo, logic [31:0] len);
      logic [32:0] e;
      logic [31:0] r;
      e = {1'b0, lo} + ((width_q == 0) ? 33'd1 : {1'b0, width_q});
      r = e[32] ? 32'hFFFF_FFFF : e[31:0];
      if (len > lo && r > len) r = len;
      return r;
    endfunction

    function logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return r;
    endfunction

    function logic [63:0] uadd(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
      logic [64:0] r;
      r = {1'b0, a} + {1'b0, b};
      return (r > {1'b0, lim}) ? lim : r[63:0];
    endfunction

    function logic [63:0] square_bases(logic signed [63:0] v, logic [63:0] n);
      logic [63:0] mag, sq;
      logic [127:0] p;
      mag = v < 0 ? -v : v;
      sq = (mag * mag) >> 16;
      p = sq * n;
      return (p > {65'd0, M63}) ? {1'b0, M63} : p[63:0];
    endfunction

    function void fold(logic signed [63:0] v, logic [63:0] n);
      logic [63:0] nb;
      nb = uadd({32'd0, bases_q}, n, {32'd0, M32});
      bases_q = nb[31:0];
      if (v < bmin) bmin = v;
      if (v > bmax) bmax = v;
      bsum = sadd(bsum, v * $signed(n));
      bsq = uadd(bsq, square_bases(v, n), {1'b0, M63});
    endfunction

    function void open_at(logic [31:0] lo, logic [31:0] len, logic signed [63:0] v);
      lo_q = lo; hi_q = bin_end(lo, len); bases_q = 0;
      bmin = v; bmax = v; bsum = 0; bsq = 0;
    endfunction

    function void push_bin(bit k, logic [15:0] c, logic [31:0] f, logic [31:0] l,
                           logic [63:0] cnt, logic signed [63:0] mn, logic signed [63:0] mx,
                           logic signed [63:0] sm, logic [63:0] sq, bit er);
      summary_t r;
      r.kind = k; r.chrom = c; r.first = f; r.last_b = l; r.count = cnt[47:0];
      r.min = mn[31:0]; r.max = mx[31:0]; r.sum = sm; r.sumsq = sq[62:0];
      r.err = er; r.fin = 0;
      pending.push_back(r);
    endfunction

    function void note_input(interval_t it);
      int before_n, splits;
      bit close, fresh;
      logic [31:0] e, hi, lo, cur, a, b;
      logic [63:0] size, rem, ov;
      logic signed [63:0] v;
      summary_t r;
      before_n = pending.size();
      splits = 0;
      v = it.v;
      if (it.op == OP_ITEM) begin
        e = (it.e < it.s) ? it.s : it.e;
        size = {32'd0, e - it.s};
        close = open_q && (it.chrom != chrom_q || it.s >= hi_q);
        fresh = close || !open_q;
        hi = fresh ? bin_end(it.s, it.len) : hi_q;
        while (e > hi && splits <= MaxSplitBins) begin
          lo = hi; hi = bin_end(lo, it.len); splits++;
        end
        if (int'(close) + splits > MaxSplitBins) begin
          push_bin(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        end else begin
          if (!seen_q) begin
            seen_q = 1; tmin = v; tmax = v;
          end
          tbases = uadd(tbases, size, {16'd0, M48});
          if (v < tmin) tmin = v;
          if (v > tmax) tmax = v;
          tsum = sadd(tsum, v * $signed(size));
          tsq = uadd(tsq, square_bases(v, size), {1'b0, M63});
          if (close) begin
            push_bin(0, chrom_q, lo_q, hi_q, {32'd0, bases_q}, bmin, bmax, bsum, bsq, 0);
            open_q = 0;
          end
          if (!open_q) begin
            open_q = 1; chrom_q = it.chrom; open_at(it.s, it.len, v);
          end
          rem = size; cur = it.s;
          while (e > hi_q) begin
            a = cur > lo_q ? cur : lo_q;
            b = e < hi_q ? e : hi_q;
            ov = b > a ? {32'd0, b - a} : 64'd0;
            fold(v, ov);
            push_bin(0, chrom_q, lo_q, hi_q, {32'd0, bases_q}, bmin, bmax, bsum, bsq, 0);
            rem = ov <= rem ? rem - ov : 64'd0;
            cur = hi_q;
            open_at(cur, it.len, v);
          end
          fold(v, rem);
        end
      end else if (it.op == OP_EOC || it.op == OP_EOA) begin
        if (open_q) begin
          push_bin(0, chrom_q, lo_q, hi_q, {32'd0, bases_q}, bmin, bmax, bsum, bsq, 0);
          open_q = 0;
        end
        if (it.op == OP_EOA) begin
          push_bin(1, 0, 0, 0, tbases, tmin, tmax, tsum, tsq, 0);
          seen_q = 0; tbases = 0; tmin = 0; tmax = 0; tsum = 0; tsq = 0;
        end
      end
      if (pending.size() > before_n) begin
        r = pending.pop_back(); r.fin = 1; pending.push_back(r);
      end
    endfunction

    function void check_result(summary_t got);
      summary_t x;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat kind=%0d chrom=%0d", got.kind, got.chrom);
        return;
      end
      x = pending.pop_front();
      if (got !== x) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("beat mismatch exp: k%0d c%0d %0d..%0d n%0d mn%0d mx%0d s%0d q%0d e%0d l%0d",
                   x.kind, x.chrom, x.first, x.last_b, x.count, x.min, x.max, x.sum,
                   x.sumsq, x.err, x.fin);
          $display("               got: k%0d c%0d %0d..%0d n%0d mn%0d mx%0d s%0d q%0d e%0d l%0d",
                   got.kind, got.chrom, got.first, got.last_b, got.count, got.min, got.max,
                   got.sum, got.sumsq, got.err, got.fin);
        end
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic push = 0, pop = 0;
  logic full, empty;
  logic [1:0] in_op = 0;
  logic [15:0] in_chrom_id = 0;
  logic [31:0] in_chrom_length = 0, in_item_start = 0, in_item_end = 0;
  logic signed [31:0] in_item_value = 0;
  logic out_kind, out_error, out_last;
  logic [15:0] out_out_chrom;
  logic [31:0] out_bin_first, out_bin_last;
  logic [47:0] out_valid_count;
  logic signed [31:0] out_min_val, out_max_val;
  logic signed [63:0] out_sum_data;
  logic [62:0] out_sum_squares;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  bin_summary_predictor board = new();
  int unsigned cycle_count = 0;
  int hold_off = 0;
  bit stall_mode = 0;

  // stream cursor for well-formed sequences
  logic [15:0] cur_chrom = 1;
  logic [31:0] cur_pos = 0, cur_len = 100000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  binned_interval_summary i_dut (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    summary_t got;
    if (rst_n && pop && !empty) begin
      got.kind = out_kind; got.chrom = out_out_chrom; got.first = out_bin_first;
      got.last_b = out_bin_last; got.count = out_valid_count; got.min = out_min_val;
      got.max = out_max_val; got.sum = out_sum_data; got.sumsq = out_sum_squares;
      got.err = out_error; got.fin = out_last;
      board.check_result(got);
    end
  end

  // receiver stall pattern, with long hold-offs on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 0;
    end else if (stall_mode) begin
      pop <= ($urandom_range(0, 3) != 0);
    end else begin
      pop <= 1;
    end
  end

  task automatic write_width(logic [31:0] w);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_BIN_WIDTH; pwdata <= w;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.width_q = w;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send(interval_t it);
    @(negedge clk);
    push <= 1; in_op <= it.op; in_chrom_id <= it.chrom; in_chrom_length <= it.len;
    in_item_start <= it.s; in_item_end <= it.e; in_item_value <= it.v;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_input(it);
  endtask

  task automatic gap();
    @(negedge clk);
    push <= 0;
  endtask

  task automatic drain();
    gap();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30 + 7 * 64) @(posedge clk);
  endtask

  task automatic one(logic [1:0] op, logic [15:0] c, logic [31:0] len, logic [31:0] s,
                     logic [31:0] e, logic [31:0] v);
    interval_t it;
    it.op = op; it.chrom = c; it.len = len; it.s = s; it.e = e; it.v = v;
    send(it);
  endtask

  function automatic interval_t random_beat();
    interval_t it;
    int pick;
    logic [31:0] w;
    pick = $urandom_range(0, 99);
    it.v = $urandom();
    if ($urandom_range(0, 3) == 0) it.v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    it.chrom = cur_chrom; it.len = cur_len;
    it.op = OP_ITEM;
    if (pick < 5) begin
      it.op = OP_EOC;
      it.chrom = $urandom(); it.len = $urandom(); it.s = $urandom(); it.e = $urandom();
      cur_chrom = $urandom(); cur_pos = $urandom_range(0, 1000);
      cur_len = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(500, 200000);
    end else if (pick < 8) begin
      it.op = OP_EOA;
      it.chrom = $urandom(); it.len = $urandom(); it.s = $urandom(); it.e = $urandom();
    end else if (pick < 10) begin
      it.op = OP_IGNORED; it.chrom = $urandom(); it.s = $urandom(); it.e = $urandom();
    end else if (pick < 18) begin
      it.chrom = $urandom(); it.len = $urandom(); it.s = $urandom(); it.e = $urandom();
    end else begin
      w = board.width_q == 0 ? 1 : board.width_q;
      cur_pos = cur_pos + $urandom_range(0, 300);
      it.s = cur_pos;
      if ($urandom_range(0, 9) == 0 && w <= 4096) it.e = cur_pos + w * $urandom_range(1, 70);
      else it.e = cur_pos + $urandom_range(0, 400);
      if ($urandom_range(0, 29) == 0) it.e = cur_pos - 1;
      if (it.e >= cur_pos) cur_pos = it.e;
    end
    return it;
  endfunction

  task automatic random_phase(int count, bit pressure);
    int burst;
    int k;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send(random_beat());
        k++;
      end
      if ($urandom_range(0, 2) == 0) begin
        gap();
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  endtask

  initial begin
    board.clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: field extremes, every op, special cases
    one(OP_EOA, 0, 0, 0, 0, 0);
    one(OP_ITEM, 16'hFFFF, 32'hFFFF_FFFF, 0, 100, 32'h7FFF_FFFF);
    one(OP_ITEM, 16'hFFFF, 32'hFFFF_FFFF, 100, 612, 32'h8000_0000);
    one(OP_ITEM, 16'hFFFF, 32'hFFFF_FFFF, 700, 650, 32'h0001_0000);
    one(OP_ITEM, 16'h0000, 1000, 900, 1100, 32'hFFFF_0000);
    one(OP_ITEM, 16'h0000, 1000, 2000, 2300, 32'h0000_8000);
    one(OP_EOC, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    one(OP_ITEM, 5, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    one(OP_ITEM, 5, 32'hFFFF_FFFF, 0, 256 * 70, 3);
    one(OP_ITEM, 5, 32'hFFFF_FFFF, 0, 256 * 62, 3);
    one(OP_IGNORED, 1, 2, 3, 4, 5);
    one(OP_EOA, 0, 0, 0, 0, 0);
    drain();

    write_width(32'd0);
    one(OP_ITEM, 2, 50, 10, 40, 32'h0002_0000);
    one(OP_ITEM, 2, 50, 100, 101, 32'h8000_0000);
    one(OP_EOA, 0, 0, 0, 0, 0);
    drain();

    write_width(32'hFFFF_FFFF);
    one(OP_ITEM, 3, 0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    one(OP_ITEM, 3, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    one(OP_EOA, 0, 0, 0, 0, 0);
    drain();

    // random phases at several widths, most with receiver stalls
    write_width(32'd1000);
    stall_mode = 1;
    random_phase(120, 0);
    gap();
    hold_off = 600;
    random_phase(60, 1);
    drain();

    write_width(32'd1);
    random_phase(60, 0);
    drain();

    write_width(32'd37);
    stall_mode = 0;
    random_phase(120, 0);
    drain();

    write_width(32'd256);
    stall_mode = 1;
    random_phase(120, 0);
    one(OP_EOA, 0, 0, 0, 0, 0);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/bis_pkg.sv
hw/rtl/bis_front.sv
hw/rtl/bis_outq.sv
hw/rtl/bis_back.sv
hw/rtl/binned_interval_summary.sv
sim/binned_interval_summary_test.sv
